/* rtl/bcrc_pkg.sv */
// bcrc_pkg: widths, mode codes and byte-wide fold functions for the CRC engine.
// No dependencies; used by bcrc_byte_if, bcrc_result_if and byte_crc32c_crc16_engine.
package bcrc_pkg;

	localparam int CRC_W  = 32;
	localparam int CRC16_W = 16;
	localparam int BYTE_W = 8;

	localparam logic [CRC_W-1:0]   POLY32C_REFL = 32'h82F6_3B78;
	localparam logic [CRC16_W-1:0] POLY16_CCITT = 16'h1021;

	typedef logic [CRC_W-1:0]   crc_t;
	typedef logic [CRC16_W-1:0] crc16_t;
	typedef logic [BYTE_W-1:0]  byte_t;

	// crc_mode register codes
	localparam logic MODE_CRC32C = 1'b0;
	localparam logic MODE_CRC16  = 1'b1;

	// reflected CRC32C, one byte, LSB first
	function automatic crc_t fold32c(input crc_t crc, input byte_t data);
		crc_t r;
		r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		for (int k = 0; k < BYTE_W; k++) begin
			r = r[0] ? ((r >> 1) ^ POLY32C_REFL) : (r >> 1);
		end
		return r;
	endfunction

	// CRC16 poly 0x1021, one byte, MSB first
	function automatic crc16_t fold16(input crc16_t crc, input byte_t data);
		crc16_t r;
		r = crc ^ {data, {(CRC16_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			r = r[CRC16_W-1] ? ((r << 1) ^ POLY16_CCITT) : (r << 1);
		end
		return r;
	endfunction

endpackage

/* rtl/bcrc_byte_if.sv */
// bcrc_byte_if: input channel, one message byte per word with seed and framing marks.
// Depends on bcrc_pkg.
interface bcrc_byte_if;
	logic            valid;
	logic            ready;
	logic            first_byte;
	bcrc_pkg::crc_t  seed_value;
	bcrc_pkg::byte_t data_byte;
	logic            last_byte;

	modport source (output valid, first_byte, seed_value, data_byte, last_byte,
		input ready);
	modport sink (input valid, first_byte, seed_value, data_byte, last_byte,
		output ready);
endinterface

/* rtl/bcrc_result_if.sv */
// bcrc_result_if: result channel carrying the finished checksum.
// Depends on bcrc_pkg.
interface bcrc_result_if;
	logic           valid;
	logic           ready;
	bcrc_pkg::crc_t crc_value;

	modport source (output valid, crc_value, input ready);
	modport sink (input valid, crc_value, output ready);
endinterface

/* rtl/bcrc_cfg_if.sv */
// bcrc_cfg_if: configuration write channel for the crc_mode register.
// No dependencies.
interface bcrc_cfg_if;
	logic valid;
	logic ready;
	logic crc_mode;

	modport source (output valid, crc_mode, input ready);
	modport sink (input valid, crc_mode, output ready);
endinterface

/* rtl/byte_crc32c_crc16_engine.sv */
// byte_crc32c_crc16_engine: byte-serial CRC32C (reflected) / CRC16 (0x1021) engine.
// Depends on bcrc_pkg, bcrc_byte_if, bcrc_result_if, bcrc_cfg_if.
// Throughput: one byte per cycle, but a last byte stalls while the result register is
// full and crc_out.ready is low; the byte fold is a single XOR network between the
// input register and the checksum/result registers, which hold the finished checksum.
// Reset (arst_n low): checksum register and crc_mode cleared, pipeline emptied.
module byte_crc32c_crc16_engine (
	input  logic          clk,
	input  logic          arst_n,
	bcrc_byte_if.sink     byte_in,
	bcrc_result_if.source crc_out,
	bcrc_cfg_if.sink      cfg
);

	logic            mode_q;
	bcrc_pkg::crc_t  crc_q;

	logic            valid_s1;
	logic            first_s1;
	logic            last_s1;
	bcrc_pkg::crc_t  seed_s1;
	bcrc_pkg::byte_t data_s1;

	logic            out_valid_q;
	bcrc_pkg::crc_t  out_crc_q;

	logic            adv_s1;
	logic            take_in;
	bcrc_pkg::crc_t  start_crc;
	bcrc_pkg::crc_t  next_crc;

	// a non-last word never needs the result register, so it never stalls
	assign adv_s1  = valid_s1 && (!last_s1 || !out_valid_q || crc_out.ready);
	assign byte_in.ready = !valid_s1 || adv_s1;
	assign take_in = byte_in.valid && byte_in.ready;
	assign cfg.ready = 1'b1;

	assign crc_out.valid     = out_valid_q;
	assign crc_out.crc_value = out_crc_q;

	always_comb begin
		start_crc = first_s1 ? seed_s1 : crc_q;
		if (mode_q == bcrc_pkg::MODE_CRC16) begin
			next_crc = {{(bcrc_pkg::CRC_W-bcrc_pkg::CRC16_W){1'b0}},
				bcrc_pkg::fold16(start_crc[bcrc_pkg::CRC16_W-1:0], data_s1)};
		end else begin
			next_crc = bcrc_pkg::fold32c(start_crc, data_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= bcrc_pkg::MODE_CRC32C;
			crc_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				mode_q <= cfg.crc_mode;
			end
			if (adv_s1) begin
				crc_q <= next_crc;
			end
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (crc_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			first_s1 <= byte_in.first_byte;
			last_s1  <= byte_in.last_byte;
			seed_s1  <= byte_in.seed_value;
			data_s1  <= byte_in.data_byte;
		end
		if (adv_s1 && last_s1) begin
			out_crc_q <= next_crc;
		end
	end

endmodule

/* dv/testbench.sv */
// testbench: self-checking bench for byte_crc32c_crc16_engine, CRC32C and CRC16 modes.
// Depends on bcrc_pkg, bcrc_byte_if, bcrc_result_if, bcrc_cfg_if and the engine RTL.
// Directed framing and mode cases first, then random messages under four idling phases.
`timescale 1ns / 100ps

module testbench;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_ITEMS = 300;
	localparam int DRAIN_CYCLES = 3;
	localparam int TAIL_CYCLES = 10;

	// running checksum predictor plus the queue of checksums still owed by the engine
	class crc_tracker;
		logic cur_mode;
		bcrc_pkg::crc_t running;
		bcrc_pkg::crc_t pending_crcs[$];
		int mismatches;

		function new();
			cur_mode = bcrc_pkg::MODE_CRC32C;
			running = '0;
			mismatches = 0;
		endfunction

		function void set_mode(logic m);
			cur_mode = m;
		endfunction

		function bcrc_pkg::crc_t step32c(bcrc_pkg::crc_t r, bcrc_pkg::byte_t d);
			r = r ^ bcrc_pkg::crc_t'(d);
			for (int k = 0; k < 8; k++) begin
				if (r[0])
					r = (r >> 1) ^ 32'h82F6_3B78;
				else
					r = r >> 1;
			end
			return r;
		endfunction

		function bcrc_pkg::crc16_t step16(bcrc_pkg::crc16_t r, bcrc_pkg::byte_t d);
			r = r ^ {d, 8'h00};
			for (int k = 0; k < 8; k++) begin
				if (r[15])
					r = (r << 1) ^ 16'h1021;
				else
					r = r << 1;
			end
			return r;
		endfunction

		function void note_byte(bit first, bcrc_pkg::crc_t seed, bcrc_pkg::byte_t d,
				bit last);
			bcrc_pkg::crc_t r;
			r = first ? seed : running;
			if (cur_mode == bcrc_pkg::MODE_CRC32C)
				r = step32c(r, d);
			else
				r = {16'h0000, step16(r[15:0], d)};
			running = r;
			if (last)
				pending_crcs.push_back(r);
		endfunction

		function void report(string what, bcrc_pkg::crc_t want, bcrc_pkg::crc_t got);
			if (mismatches < 10)
				$display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
			mismatches++;
		endfunction

		function void check_crc(bcrc_pkg::crc_t got);
			bcrc_pkg::crc_t want;
			if (pending_crcs.size() == 0) begin
				report("checksum word with none pending", 'x, got);
			end else begin
				want = pending_crcs.pop_front();
				if (got !== want)
					report("crc_value mismatch", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int send_pct;
	int stall_pct = 0;
	int idle_cycles;
	crc_tracker tracker;

	bcrc_byte_if byte_if();
	bcrc_result_if res_if();
	bcrc_cfg_if cfg_if();

	byte_crc32c_crc16_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_in(byte_if),
		.crc_out(res_if),
		.cfg    (cfg_if)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			tracker.check_crc(res_if.crc_value);
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
			$display("[byte_crc32c_crc16_engine] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// valid is left high after acceptance so back-to-back words keep it up;
	// every path that lets time pass lowers it first
	task automatic send_byte(input bit first, input bcrc_pkg::crc_t seed,
			input bcrc_pkg::byte_t d, input bit last);
		while ($urandom_range(99) < send_pct) begin
			byte_if.valid <= 1'b0;
			@(posedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.first_byte <= first;
		byte_if.seed_value <= seed;
		byte_if.data_byte <= d;
		byte_if.last_byte <= last;
		do
			@(posedge clk);
		while (!byte_if.ready);
		tracker.note_byte(first, seed, d, last);
	endtask

	// sender holds off until every checksum is in, then lets the engine settle
	task automatic wait_drain();
		byte_if.valid <= 1'b0;
		while (tracker.pending_crcs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_if.valid <= 1'b1;
		cfg_if.crc_mode <= m;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		tracker.set_mode(m);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic bcrc_pkg::crc_t pick_seed();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic bcrc_pkg::byte_t pick_byte();
		return bcrc_pkg::byte_t'($urandom_range(255));
	endfunction

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(i == 0, pick_seed(), pick_byte(), i == len - 1);
	endtask

	task automatic run_phase(input int s_pct, input int r_pct);
		int count;
		int len;
		bit split_done;
		count = 0;
		split_done = 0;
		send_pct = s_pct;
		stall_pct = r_pct;
		while (count < PHASE_ITEMS) begin
			if (!split_done && count >= PHASE_ITEMS / 2) begin
				// message split across a mode change, with the sender fully drained
				send_byte(1'b1, pick_seed(), pick_byte(), 1'b0);
				send_byte(1'b0, pick_seed(), pick_byte(), 1'b0);
				wait_drain();
				write_mode(~tracker.cur_mode);
				send_byte(1'b0, pick_seed(), pick_byte(), 1'b0);
				send_byte(1'b0, pick_seed(), pick_byte(), 1'b1);
				count += 4;
				split_done = 1;
			end else if ($urandom_range(99) < 8) begin
				// loose word with random framing marks
				send_byte(1'($urandom_range(1)), pick_seed(), pick_byte(),
					1'($urandom_range(1)));
				count++;
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
				send_message(len);
				count += len;
			end
		end
	endtask

	initial begin
		tracker = new();
		send_pct = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.first_byte = 1'b0;
		byte_if.seed_value = '0;
		byte_if.data_byte = '0;
		byte_if.last_byte = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.crc_mode = bcrc_pkg::MODE_CRC32C;
		res_if.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// CRC32C from reset: no first mark, so the fold starts from zero
		send_byte(1'b0, 32'hDEAD_BEEF, 8'h31, 1'b1);
		send_byte(1'b1, 32'h0000_0000, 8'h00, 1'b1);
		send_byte(1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		send_byte(1'b1, 32'hAAAA_5555, 8'h80, 1'b1);
		for (int i = 0; i < 9; i++)
			send_byte(i == 0, 32'hFFFF_FFFF, bcrc_pkg::byte_t'(8'h31 + i), i == 8);
		send_byte(1'b0, 32'h0000_0000, 8'h01, 1'b1);
		wait_drain();

		write_mode(bcrc_pkg::MODE_CRC16);
		send_byte(1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		send_byte(1'b1, 32'h0000_0000, 8'h00, 1'b1);
		for (int i = 0; i < 9; i++)
			send_byte(i == 0, 32'h0000_FFFF, bcrc_pkg::byte_t'(8'h31 + i), i == 8);

		// CRC16 partial, then CRC32C continues from the 16-bit register
		send_byte(1'b1, 32'h1234_ABCD, 8'h5A, 1'b0);
		send_byte(1'b0, 32'h0000_0000, 8'hA5, 1'b0);
		wait_drain();
		write_mode(bcrc_pkg::MODE_CRC32C);
		send_byte(1'b0, 32'hFFFF_FFFF, 8'h3C, 1'b1);

		// CRC32C partial, then a CRC16 fold drops the upper half
		send_byte(1'b1, 32'hFEDC_BA98, 8'h77, 1'b0);
		wait_drain();
		write_mode(bcrc_pkg::MODE_CRC16);
		send_byte(1'b0, 32'h0000_0000, 8'h88, 1'b1);

		for (int p = 0; p < 4; p++) begin
			wait_drain();
			write_mode(p[0] ? bcrc_pkg::MODE_CRC16 : bcrc_pkg::MODE_CRC32C);
			case (p)
				0: run_phase(0, 0);
				1: run_phase(63, 0);
				2: run_phase(0, 63);
				default: run_phase(25, 25);
			endcase
		end

		byte_if.valid <= 1'b0;
		while (tracker.pending_crcs.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending_crcs.size() == 0) begin
			$display("[byte_crc32c_crc16_engine] OK");
		end else begin
			$display("[byte_crc32c_crc16_engine] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/bcrc_pkg.sv
rtl/bcrc_byte_if.sv
rtl/bcrc_result_if.sv
rtl/bcrc_cfg_if.sv
rtl/byte_crc32c_crc16_engine.sv
dv/testbench.sv
